[rtl/image_diff_statistics_defines.svh]
// ---------------------------------------------------------------------------
// Image diff statistics assertion macros
// Shared helpers for the concurrent checks of the image diff statistics block.
// ---------------------------------------------------------------------------
`ifndef IMAGE_DIFF_STATISTICS_DEFINES_SVH
`define IMAGE_DIFF_STATISTICS_DEFINES_SVH

// Same-cycle implication, clocked on clk and held off during rst.
`define IDS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("image_diff_statistics: same-cycle check failed");

// Next-cycle implication, clocked on clk and held off during rst.
`define IDS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("image_diff_statistics: next-cycle check failed");

`endif

[rtl/ids_pkg.sv]
// ---------------------------------------------------------------------------
// Image diff statistics package
// Request and result types, operation codes, sequencer states and constants.
// ---------------------------------------------------------------------------
package ids_pkg;

  localparam int HIST_BINS = 256;
  localparam int BIN_W     = 8;
  localparam int THR_W     = 9;
  localparam int ACC_W     = 48;

  // Operation codes of a request.
  localparam logic [1:0] OP_PIXEL = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [THR_W-1:0] THR_RESET   = 9'd4;
  localparam logic [31:0]      COLOR_WHITE = 32'hFFFF_FFFF;
  localparam logic [7:0]       COLOR_ALPHA = 8'hFF;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] pixel_test;
    logic [31:0] pixel_ref;
    logic [7:0]  bin_index;
  } ids_req_t;

  typedef struct packed {
    logic [31:0]      pixel_color;
    logic [7:0]       max_diff;
    logic [31:0]      bin_count;
    logic [ACC_W-1:0] rel_diff_sum;
  } ids_rsp_t;

  // Command from the sequencer to the histogram memory.
  typedef struct packed {
    logic             incr;
    logic             rd;
    logic             clr;
    logic [BIN_W-1:0] bin;
  } ids_hist_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHAN,
    ST_DIV,
    ST_RD,
    ST_FIN
  } ids_state_t;

endpackage

[rtl/image_diff_statistics.sv]
// ---------------------------------------------------------------------------
// Image diff statistics
// Per-pixel absolute difference with histogram, running maximum and a
// saturating sum of relative differences.
// ---------------------------------------------------------------------------
// Channel   Signals                    Direction  Transfer
// request   start, busy, req           in         start && !busy
// result    done, rsp                  out        done, one cycle
// config    cfg_valid, cfg_ready, cfg_data  in    cfg_valid && cfg_ready
//
// A pixel request runs the shared bit-serial divider, one quotient bit per
// cycle, for each of the three channels in turn. A bin read passes through
// ST_RD and ST_FIN, a clear or an unused code through ST_FIN alone. Results
// cannot be stalled; done rises the cycle busy falls. Reset clears the
// statistics at once through valid bits.
// ---------------------------------------------------------------------------
`include "image_diff_statistics_defines.svh"

module image_diff_statistics #(
  parameter int COUNT_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  ids_pkg::ids_req_t       req,
  output logic                    done,
  output ids_pkg::ids_rsp_t       rsp,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [ids_pkg::THR_W-1:0] cfg_data
);

  import ids_pkg::*;

  localparam int DW    = 8 + FRAC_BITS;
  localparam int SUM_W = DW + 2;

  ids_state_t             state;
  ids_state_t             state_next;
  ids_req_t               req_q;
  logic [1:0]             ch;
  logic [7:0]             cur_d;
  logic [7:0]             cur_b;
  logic [7:0]             dmax;
  logic [SUM_W-1:0]       sum;
  logic [7:0]             running_max;
  logic [ACC_W-1:0]       acc;
  logic [THR_W-1:0]       threshold;
  ids_rsp_t               rsp_next;
  logic [7:0]             max_next;
  logic [ACC_W-1:0]       acc_next;
  logic [ACC_W:0]         acc_sum;
  logic [7:0]             chan_a;
  logic [7:0]             chan_b;
  logic [7:0]             chan_d;
  logic [DW-1:0]          term;
  ids_hist_cmd_t          hist_cmd;
  logic [COUNT_WIDTH-1:0] hist_count;
  logic [31:0]            count32;
  logic                   div_start;
  logic [DW-1:0]          quotient;
  logic                   div_done;

  // Shared divider for the relative differences.
  ids_div #(
    .DW(DW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend({chan_d, {FRAC_BITS{1'b0}}}),
    .divisor (chan_b),
    .quotient(quotient),
    .done    (div_done)
  );

  // Histogram bin memory.
  ids_hist #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_hist (
    .clk  (clk),
    .rst  (rst),
    .cmd  (hist_cmd),
    .count(hist_count)
  );

  // Bin counts wider than the result field saturate.
  if (COUNT_WIDTH > 32) begin : g_sat
    assign count32 = (|hist_count[COUNT_WIDTH-1:32]) ? 32'hFFFF_FFFF : hist_count[31:0];
  end else begin : g_ext
    assign count32 = 32'(hist_count);
  end

  // Current channel difference from the latched pixel pair.
  always_comb begin
    chan_a = req_q.pixel_test[{ch, 3'b000} +: 8];
    chan_b = req_q.pixel_ref[{ch, 3'b000} +: 8];
    chan_d = (chan_a > chan_b) ? (chan_a - chan_b) : (chan_b - chan_a);
    term   = (cur_b == 8'd0) ? {cur_d, {FRAC_BITS{1'b0}}} : quotient;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (req.op)
            OP_PIXEL: state_next = ST_CHAN;
            OP_READ:  state_next = ST_RD;
            default:  state_next = ST_FIN;
          endcase
        end
      end
      ST_CHAN: state_next = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_next = (ch == 2'd2) ? ST_FIN : ST_CHAN;
        end
      end
      ST_RD:   state_next = ST_FIN;
      ST_FIN:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    busy          = (state != ST_IDLE);
    cfg_ready     = (state == ST_IDLE);
    div_start     = (state == ST_CHAN);
    hist_cmd.incr = (state == ST_CHAN);
    hist_cmd.rd   = (state == ST_RD);
    hist_cmd.clr  = (state == ST_FIN) && (req_q.op == OP_CLEAR);
    hist_cmd.bin  = (state == ST_RD) ? req_q.bin_index : chan_d;
  end

  // Result of the finishing cycle.
  always_comb begin
    acc_sum  = {1'b0, acc} + (ACC_W + 1)'(sum);
    max_next = running_max;
    acc_next = acc;
    rsp_next.pixel_color = '0;
    rsp_next.bin_count   = '0;
    case (req_q.op)
      OP_PIXEL: begin
        max_next = (dmax > running_max) ? dmax : running_max;
        acc_next = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
        if ({1'b0, dmax} >= threshold) begin
          rsp_next.pixel_color = {COLOR_ALPHA, 8'h00, ~dmax, dmax};
        end else begin
          rsp_next.pixel_color = COLOR_WHITE;
        end
      end
      OP_READ: begin
        rsp_next.bin_count = count32;
      end
      OP_CLEAR: begin
        max_next = '0;
        acc_next = '0;
      end
      default: begin
        max_next = running_max;
      end
    endcase
    rsp_next.max_diff     = max_next;
    rsp_next.rel_diff_sum = acc_next;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      done        <= 1'b0;
      running_max <= '0;
      acc         <= '0;
      threshold   <= THR_RESET;
    end else begin
      state <= state_next;
      done  <= (state == ST_FIN);
      if (state == ST_FIN) begin
        running_max <= max_next;
        acc         <= acc_next;
      end
      if (cfg_valid && cfg_ready) begin
        threshold <= cfg_data;
      end
    end
  end

  // Request and per-pixel working registers.
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && start) begin
      req_q <= req;
      ch    <= 2'd0;
      dmax  <= '0;
      sum   <= '0;
    end
    if (state == ST_CHAN) begin
      cur_d <= chan_d;
      cur_b <= chan_b;
    end
    if ((state == ST_DIV) && div_done) begin
      sum  <= sum + SUM_W'(term);
      dmax <= (cur_d > dmax) ? cur_d : dmax;
      ch   <= ch + 1'b1;
    end
    if (state == ST_FIN) begin
      rsp <= rsp_next;
    end
  end

  // Checks on the sequencer.
  `IDS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `IDS_ASSERT_SAME(a_done_idle, done, !busy)
  `IDS_ASSERT_NEXT(a_done_single, done, !done)
  `IDS_ASSERT_SAME(a_div_in_div, div_done, state == ST_DIV)

endmodule

[rtl/ids_div.sv]
// ---------------------------------------------------------------------------
// Image diff statistics divider
// Restoring divider, one quotient bit per cycle, 8-bit divisor.
// ---------------------------------------------------------------------------
module ids_div #(
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [7:0]    divisor,
  output logic [DW-1:0] quotient,
  output logic          done
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    dvd;
  logic [7:0]       div_q;
  logic [7:0]       rem;
  logic [8:0]       rem_sh;
  logic             qbit;
  logic [CNT_W-1:0] cnt;
  logic             running;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    rem_sh = {rem, dvd[DW-1]};
    qbit   = (rem_sh >= {1'b0, div_q});
  end

  // Operand and partial remainder registers.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd   <= dividend;
      div_q <= divisor;
      rem   <= '0;
    end else if (running) begin
      dvd <= {dvd[DW-2:0], qbit};
      rem <= qbit ? 8'(rem_sh - {1'b0, div_q}) : rem_sh[7:0];
    end
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt     <= CNT_W'(DW);
        running <= 1'b1;
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quotient = dvd;

endmodule

[rtl/ids_hist.sv]
// ---------------------------------------------------------------------------
// Image diff statistics histogram
// Bin memory with per-bin valid bits, saturating read-modify-write increment.
// ---------------------------------------------------------------------------
module ids_hist #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ids_pkg::ids_hist_cmd_t cmd,
  output logic [COUNT_WIDTH-1:0] count
);

  import ids_pkg::*;

  logic [COUNT_WIDTH-1:0] mem [HIST_BINS];
  logic [HIST_BINS-1:0]   valid;
  logic [COUNT_WIDTH-1:0] rdata;
  logic                   rvalid;
  logic                   pend;
  logic [BIN_W-1:0]       pend_bin;
  logic [COUNT_WIDTH-1:0] cur;
  logic                   wr_en;

  // A bin that was never written since the last clear reads as zero.
  assign cur   = rvalid ? rdata : '0;
  assign wr_en = pend && (cur != '1);
  assign count = cur;

  // Registered read port.
  always_ff @(posedge clk) begin
    if (cmd.incr || cmd.rd) begin
      rdata <= mem[cmd.bin];
    end
  end

  // Write port: increment the bin read in the previous cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pend_bin] <= cur + 1'b1;
    end
  end

  // Pending write address.
  always_ff @(posedge clk) begin
    pend_bin <= cmd.bin;
  end

  // Valid bits and read-modify-write control.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rvalid <= 1'b0;
      pend   <= 1'b0;
    end else begin
      pend <= cmd.incr;
      if (cmd.incr || cmd.rd) begin
        rvalid <= valid[cmd.bin];
      end
      if (cmd.clr) begin
        valid <= '0;
      end else if (wr_en) begin
        valid[pend_bin] <= 1'b1;
      end
    end
  end

endmodule

[tb/image_diff_statistics_tb.sv]
// ---------------------------------------------------------------------------
// Image diff statistics testbench
// Sends pixel, bin read, clear and unused requests through the start/busy
// handshake, predicts each result with an independent model of the histogram,
// running maximum and relative difference sum, and compares every done
// strobe with the oldest prediction. The threshold register is rewritten
// between phases while the block is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module image_diff_statistics_tb;
  import ids_pkg::*;

  localparam int          FRAC        = 16;
  localparam int          COUNT_W     = 32;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam logic [47:0] ACC_FULL    = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] BIN_FULL    = 32'hFFFF_FFFF;
  localparam int          PIXEL_LAT   = 3 * (FRAC + 10) + 1;
  localparam int          CYCLE_LIMIT = 1000000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  ids_req_t   req = '0;
  logic       done;
  ids_rsp_t   rsp;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [THR_W-1:0] cfg_data = '0;

  // Testbench bookkeeping.
  ids_req_t    request_backlog[$];
  ids_rsp_t    expected_rsp[$];
  int unsigned send_idle_pct = 6;
  logic        req_fired = 1'b0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  // Shadow copy of the block's statistics and threshold.
  logic [COUNT_W-1:0] hist_shadow[HIST_BINS];
  logic [7:0]         max_shadow;
  logic [ACC_W-1:0]   acc_shadow;
  logic [THR_W-1:0]   thr_shadow;

  image_diff_statistics #(
    .COUNT_WIDTH(COUNT_W),
    .FRAC_BITS(FRAC)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .rsp(rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Apply one request to the shadow state and return the result it produces.
  function automatic ids_rsp_t apply_request(ids_req_t q);
    ids_rsp_t    e;
    logic [7:0]  a, b, d, dmax;
    logic [63:0] scaled, sum;
    e = '0;
    case (q.op)
      OP_PIXEL: begin
        dmax = 8'd0;
        sum = 64'd0;
        for (int k = 0; k < 3; k++) begin
          a = q.pixel_test[8*k +: 8];
          b = q.pixel_ref[8*k +: 8];
          d = (a > b) ? a - b : b - a;
          if (d > dmax) dmax = d;
          if (hist_shadow[d] != BIN_FULL) hist_shadow[d] = hist_shadow[d] + 1'b1;
          scaled = 64'(d) << FRAC;
          sum = sum + ((b != 8'd0) ? scaled / 64'(b) : scaled);
        end
        if (dmax > max_shadow) max_shadow = dmax;
        if (sum > 64'(ACC_FULL - acc_shadow)) acc_shadow = ACC_FULL;
        else acc_shadow = acc_shadow + sum[ACC_W-1:0];
        if ({1'b0, dmax} >= thr_shadow) e.pixel_color = {COLOR_ALPHA, 8'h00, ~dmax, dmax};
        else e.pixel_color = COLOR_WHITE;
      end
      OP_READ: begin
        e.bin_count = hist_shadow[q.bin_index];
      end
      OP_CLEAR: begin
        for (int i = 0; i < HIST_BINS; i++) hist_shadow[i] = '0;
        max_shadow = 8'd0;
        acc_shadow = '0;
      end
      default: begin
      end
    endcase
    e.max_diff = max_shadow;
    e.rel_diff_sum = acc_shadow;
    return e;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0d ns: %s", $time, msg);
  endtask

  // Request builders.
  function automatic ids_req_t pixel_req(logic [31:0] t, logic [31:0] r);
    ids_req_t q;
    q.op = OP_PIXEL;
    q.pixel_test = t;
    q.pixel_ref = r;
    q.bin_index = 8'($urandom);
    return q;
  endfunction

  function automatic ids_req_t other_req(logic [1:0] op, logic [7:0] bin);
    ids_req_t q;
    q.op = op;
    q.pixel_test = $urandom;
    q.pixel_ref = $urandom;
    q.bin_index = bin;
    return q;
  endfunction

  // Pixel with channel pairs biased toward small differences, zero
  // references and the full-scale difference.
  function automatic ids_req_t random_pixel();
    ids_req_t    q;
    int          v;
    int unsigned mode;
    q = pixel_req($urandom, $urandom);
    for (int k = 0; k < 3; k++) begin
      mode = $urandom_range(0, 99);
      if (mode < 40) begin
        v = int'(q.pixel_test[8*k +: 8]) + int'($urandom_range(0, 12)) - 6;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        q.pixel_ref[8*k +: 8] = 8'(v);
      end else if (mode < 50) begin
        q.pixel_ref[8*k +: 8] = 8'h00;
      end else if (mode < 53) begin
        q.pixel_test[8*k +: 8] = 8'hFF;
        q.pixel_ref[8*k +: 8] = 8'h00;
      end else if (mode < 56) begin
        q.pixel_test[8*k +: 8] = 8'h00;
        q.pixel_ref[8*k +: 8] = 8'hFF;
      end
    end
    return q;
  endfunction

  function automatic ids_req_t random_request();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 72) return random_pixel();
    if (pick < 92) begin
      if ($urandom_range(0, 1) == 0) return other_req(OP_READ, 8'($urandom_range(0, 15)));
      return other_req(OP_READ, 8'($urandom));
    end
    if (pick < 97) return other_req(OP_CLEAR, 8'($urandom));
    return other_req(OP_UNUSED, 8'($urandom));
  endfunction

  // Request driver: holds a request until it is taken, then picks the next.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || req_fired) begin
      if (request_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        start <= 1'b1;
        req <= request_backlog.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Result monitor and predictor.
  always @(posedge clk) begin
    if (rst) begin
      req_fired <= 1'b0;
      for (int i = 0; i < HIST_BINS; i++) hist_shadow[i] = '0;
      max_shadow = 8'd0;
      acc_shadow = '0;
      thr_shadow = THR_RESET;
    end else begin
      req_fired <= start && !busy;
      // Check a result against the oldest prediction.
      if (done) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch("result strobe with no request outstanding");
        end else begin
          ids_rsp_t e;
          e = expected_rsp.pop_front();
          if (rsp.pixel_color !== e.pixel_color)
            report_mismatch($sformatf("pixel_color got %h want %h",
                                      rsp.pixel_color, e.pixel_color));
          if (rsp.max_diff !== e.max_diff)
            report_mismatch($sformatf("max_diff got %h want %h", rsp.max_diff, e.max_diff));
          if (rsp.bin_count !== e.bin_count)
            report_mismatch($sformatf("bin_count got %h want %h", rsp.bin_count, e.bin_count));
          if (rsp.rel_diff_sum !== e.rel_diff_sum)
            report_mismatch($sformatf("rel_diff_sum got %h want %h",
                                      rsp.rel_diff_sum, e.rel_diff_sum));
        end
      end
      // A request taken at this edge.
      if (start && !busy) expected_rsp.push_back(apply_request(req));
      if (cfg_valid && cfg_ready) thr_shadow = cfg_data;
    end
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("image_diff_statistics_tb NOT OK");
      $finish;
    end
  end

  // Wait until every queued request has been taken and answered.
  task automatic wait_drained();
    do @(posedge clk);
    while (request_backlog.size() != 0 || start || expected_rsp.size() != 0);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) request_backlog.push_back(random_request());
  endtask

  // Stimulus sequence.
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed requests at the reset threshold.
    send_idle_pct = 6;
    request_backlog.push_back(pixel_req(32'h0000_0000, 32'h0000_0000));
    request_backlog.push_back(pixel_req(32'hFFFF_FFFF, 32'h0000_0000));
    request_backlog.push_back(pixel_req(32'h0000_0000, 32'hFFFF_FFFF));
    request_backlog.push_back(pixel_req(32'hFF00_0000, 32'h0000_0000));
    request_backlog.push_back(pixel_req(32'h0000_0003, 32'h0000_0000));
    request_backlog.push_back(pixel_req(32'h0004_0000, 32'h0000_0000));
    request_backlog.push_back(pixel_req(32'h0000_8000, 32'h0000_1000));
    request_backlog.push_back(pixel_req(32'h0001_0101, 32'h0003_0702));
    request_backlog.push_back(other_req(OP_READ, 8'd0));
    request_backlog.push_back(other_req(OP_READ, 8'd255));
    request_backlog.push_back(other_req(OP_READ, 8'd4));
    request_backlog.push_back(other_req(OP_READ, 8'd3));
    request_backlog.push_back(other_req(OP_READ, 8'd1));
    request_backlog.push_back(other_req(OP_UNUSED, 8'($urandom)));
    request_backlog.push_back(other_req(OP_CLEAR, 8'd0));
    request_backlog.push_back(other_req(OP_READ, 8'd255));
    request_backlog.push_back('1);
    request_backlog.push_back(pixel_req(32'hAAAA_AAAA, 32'h5555_5555));
    request_backlog.push_back(pixel_req(32'h5555_5555, 32'hAAAA_AAAA));
    request_backlog.push_back(other_req(OP_READ, 8'h55));
    request_backlog.push_back({OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF});
    request_backlog.push_back(other_req(OP_READ, 8'hAA));
    wait_drained();

    // Lowest threshold: every pixel is colored.
    write_threshold(9'd0);
    queue_random(300);
    wait_drained();

    // Threshold above any difference, with a sparse sender.
    send_idle_pct = 85;
    write_threshold(9'd256);
    queue_random(300);
    wait_drained();

    // Highest reachable threshold, back to back.
    send_idle_pct = 0;
    write_threshold(9'd255);
    queue_random(300);
    wait_drained();

    // A mid-range threshold.
    write_threshold(9'($urandom_range(1, 254)));
    queue_random(400);
    wait_drained();

    repeat (PIXEL_LAT + 10) @(posedge clk);
    if (mismatches == 0 && expected_rsp.size() == 0) begin
      $display("image_diff_statistics_tb OK");
    end else begin
      $display("image_diff_statistics_tb NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/ids_pkg.sv
rtl/ids_div.sv
rtl/ids_hist.sv
rtl/image_diff_statistics.sv
tb/image_diff_statistics_tb.sv
